// ===== design/lir_pkg.sv =====
// ----------------------------------------------------------------------------
// lir_pkg
// Shared types and constants of the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

  localparam int RATE_W = 18;
  localparam int CMD_W  = 2;
  localparam int REG_W  = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_PULL  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [REG_W-1:0] {
    REG_IN_RATE  = 1'b0,
    REG_OUT_RATE = 1'b1
  } reg_idx_t;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_LEN  = 10'b00_0000_0010,
    ST_SPAN = 10'b00_0000_0100,
    ST_WF   = 10'b00_0000_1000,
    ST_CHK  = 10'b00_0001_0000,
    ST_RDR  = 10'b00_0010_0000,
    ST_MUL  = 10'b00_0100_0000,
    ST_DIVS = 10'b00_1000_0000,
    ST_IDIV = 10'b01_0000_0000,
    ST_OUT  = 10'b10_0000_0000
  } state_t;

endpackage

// ===== design/linear_interp_resampler_top.sv =====
// ----------------------------------------------------------------------------
// linear_interp_resampler_top
// Block resampler by linear interpolation with an exact rational phase.
// ----------------------------------------------------------------------------
// Push, clear and no-op transactions are taken while the block is idle and
// leave it idle. A pull holds off the input from the pull until its result is
// taken. The first pull of a block adds the length and step divisions, or only
// the step division when the two rates are equal. A pull on an empty block
// answers straight from the idle state, and a pull past the end of the block
// answers from the check state. How long a pull takes is set by the one shared
// divider, which retires one quotient bit per cycle, and by the single read
// port of the sample store, which gives both neighbors in turn.
// Results wait in an output register until taken.
module linear_interp_resampler_top
  import lir_pkg::*;
#(
  parameter int MAX_IN      = 1024,
  parameter int MAX_OUT     = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [REG_W-1:0]                     cfg_index,
  input  logic [RATE_W-1:0]                    cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [CMD_W-1:0]                     in_cmd,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        out_sample,
  output logic                                 out_last,
  output logic                                 out_none_left,
  output logic                                 out_truncated,
  output logic [$clog2(MAX_OUT+1)-1:0]         out_total_count
);

  localparam int SB     = SAMPLE_BITS;
  localparam int CNT_W  = $clog2(MAX_IN + 1);
  localparam int IDX_W  = $clog2(MAX_IN);
  localparam int OUT_W  = $clog2(MAX_OUT + 1);
  localparam int SPAN_W = CNT_W + RATE_W;
  localparam int PROD_W = SB + SPAN_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int DEN_W  = SPAN_W + 1;

  localparam logic [CNT_W-1:0]  MAX_IN_C  = CNT_W'(MAX_IN);
  localparam logic [SPAN_W-1:0] MAX_OUT_S = SPAN_W'(MAX_OUT);

  state_t state_r, state_nxt;

  logic [RATE_W-1:0] in_rate_r, out_rate_r;
  logic [CNT_W-1:0]  in_count_r, in_count_nxt;
  logic [OUT_W-1:0]  out_total_r, out_total_nxt;
  logic [OUT_W-1:0]  out_index_r, out_index_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic [SPAN_W-1:0] ph_r, ph_nxt;
  logic              len_ready_r, len_ready_nxt;
  logic              ovf_r, ovf_nxt;
  logic [SPAN_W-1:0] span_r, span_nxt;

  logic [CNT_W-1:0]  whole_r, whole_nxt;
  logic [SPAN_W-1:0] frac_r, frac_nxt;
  logic [SB-1:0]     sl_r, sl_nxt;
  logic              neg_r, neg_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              nneg_r, nneg_nxt;
  logic [SB-1:0]     samp_r, samp_nxt;
  logic              last_r, last_nxt;
  logic              none_r, none_nxt;

  logic [SB-1:0]     mem [MAX_IN];
  logic [SB-1:0]     mem_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_raddr;

  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;
  logic [DEN_W-1:0]  div_rem;

  logic [RATE_W-1:0] ir;
  logic [SPAN_W-1:0] len_prod;
  logic [NUM_W-1:0]  len_num;
  logic              fix_now;
  logic [SPAN_W-1:0] fix_n;
  logic [CNT_W-1:0]  l_pos, r_pos, l_inc;
  logic [SB:0]       diff, mag_full;
  logic [NUM_W-1:0]  two_prod, d_ext;
  logic [SB:0]       q_u;
  logic [SB+1:0]     q_ext, q_s, sl_ext, samp_sum;
  logic [SPAN_W:0]   ph_sum;
  logic              ph_carry;
  logic [CNT_W:0]    left_sum;

  lir_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_count_r[IDX_W-1:0]] <= in_sample;
    end
    mem_q <= mem[mem_raddr];
  end

  always_comb begin
    ir       = (in_rate_r == '0) ? RATE_W'(1) : in_rate_r;
    len_prod = SPAN_W'(in_count_r) * SPAN_W'(out_rate_r);
    len_num  = NUM_W'(len_prod) + NUM_W'(ir) - NUM_W'(1);
    fix_n    = (state_r == ST_LEN) ? div_quo[SPAN_W-1:0] : SPAN_W'(in_count_r);

    l_pos = (left_r >= in_count_r) ? in_count_r - CNT_W'(1) : left_r;
    l_inc = l_pos + CNT_W'(1);
    r_pos = (l_inc >= in_count_r) ? in_count_r - CNT_W'(1) : l_inc;

    diff     = {mem_q[SB-1], mem_q} - {sl_r[SB-1], sl_r};
    mag_full = diff[SB] ? (~diff + (SB+1)'(1)) : diff;

    two_prod = {prod_r, 1'b0};
    d_ext    = NUM_W'(span_r);

    q_u      = div_quo[SB:0] + (SB+1)'(nneg_r && (div_rem != '0));
    q_ext    = {1'b0, q_u};
    q_s      = nneg_r ? (~q_ext + (SB+2)'(1)) : q_ext;
    sl_ext   = {{2{sl_r[SB-1]}}, sl_r};
    samp_sum = sl_ext + q_s;

    ph_sum   = {1'b0, ph_r} + {1'b0, frac_r};
    ph_carry = (ph_sum >= {1'b0, span_r});
    left_sum = {1'b0, left_r} + {1'b0, whole_r} + (CNT_W+1)'(ph_carry);
  end

  always_comb begin
    state_nxt     = state_r;
    in_count_nxt  = in_count_r;
    out_total_nxt = out_total_r;
    out_index_nxt = out_index_r;
    left_nxt      = left_r;
    ph_nxt        = ph_r;
    len_ready_nxt = len_ready_r;
    ovf_nxt       = ovf_r;
    span_nxt      = span_r;
    whole_nxt     = whole_r;
    frac_nxt      = frac_r;
    sl_nxt        = sl_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    nneg_nxt      = nneg_r;
    samp_nxt      = samp_r;
    last_nxt      = last_r;
    none_nxt      = none_r;
    mem_we        = 1'b0;
    mem_raddr     = l_pos[IDX_W-1:0];
    div_start     = 1'b0;
    div_num       = '0;
    div_den       = '0;
    fix_now       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(in_cmd))
            CMD_PUSH: begin
              if (!len_ready_r && (in_count_r < MAX_IN_C)) begin
                mem_we       = 1'b1;
                in_count_nxt = in_count_r + CNT_W'(1);
              end
            end
            CMD_CLEAR: begin
              in_count_nxt  = '0;
              out_total_nxt = '0;
              out_index_nxt = '0;
              left_nxt      = '0;
              ph_nxt        = '0;
              len_ready_nxt = 1'b0;
              ovf_nxt       = 1'b0;
              span_nxt      = '0;
            end
            CMD_PULL: begin
              if (in_count_r == '0) begin
                samp_nxt  = '0;
                last_nxt  = 1'b0;
                none_nxt  = 1'b1;
                state_nxt = ST_OUT;
              end else if (len_ready_r) begin
                state_nxt = ST_CHK;
              end else if (in_rate_r == out_rate_r) begin
                fix_now   = 1'b1;
                state_nxt = ST_SPAN;
              end else begin
                div_start = 1'b1;
                div_num   = len_num;
                div_den   = DEN_W'(ir);
                state_nxt = ST_LEN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LEN: begin
        if (div_done) begin
          fix_now   = 1'b1;
          state_nxt = ST_SPAN;
        end
      end
      ST_SPAN: begin
        if (span_r == '0) begin
          state_nxt = ST_CHK;
        end else begin
          div_start = 1'b1;
          div_num   = NUM_W'(in_count_r);
          div_den   = DEN_W'(span_r);
          state_nxt = ST_WF;
        end
      end
      ST_WF: begin
        if (div_done) begin
          whole_nxt = div_quo[CNT_W-1:0];
          frac_nxt  = div_rem[SPAN_W-1:0];
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if ((out_index_r < out_total_r) && (span_r != '0)) begin
          mem_raddr = l_pos[IDX_W-1:0];
          state_nxt = ST_RDR;
        end else begin
          samp_nxt  = '0;
          last_nxt  = 1'b0;
          none_nxt  = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_RDR: begin
        mem_raddr = r_pos[IDX_W-1:0];
        sl_nxt    = mem_q;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        neg_nxt   = diff[SB];
        prod_nxt  = PROD_W'(mag_full[SB-1:0]) * PROD_W'(ph_r);
        state_nxt = ST_DIVS;
      end
      ST_DIVS: begin
        div_start = 1'b1;
        div_den   = {span_r, 1'b0};
        if (!neg_r) begin
          div_num  = two_prod + d_ext;
          nneg_nxt = 1'b0;
        end else if (two_prod > d_ext) begin
          div_num  = two_prod - d_ext;
          nneg_nxt = 1'b1;
        end else begin
          div_num  = d_ext - two_prod;
          nneg_nxt = 1'b0;
        end
        state_nxt = ST_IDIV;
      end
      ST_IDIV: begin
        if (div_done) begin
          samp_nxt      = samp_sum[SB-1:0];
          none_nxt      = 1'b0;
          last_nxt      = ((out_index_r + OUT_W'(1)) == out_total_r);
          ph_nxt        = ph_carry ? SPAN_W'(ph_sum - {1'b0, span_r}) : ph_sum[SPAN_W-1:0];
          left_nxt      = left_sum[CNT_W-1:0];
          out_index_nxt = out_index_r + OUT_W'(1);
          state_nxt     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fix_now) begin
      span_nxt      = fix_n;
      ovf_nxt       = (fix_n > MAX_OUT_S);
      out_total_nxt = (fix_n > MAX_OUT_S) ? OUT_W'(MAX_OUT) : fix_n[OUT_W-1:0];
      out_index_nxt = '0;
      left_nxt      = '0;
      ph_nxt        = '0;
      len_ready_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_rate_r   <= RATE_W'(48000);
      out_rate_r  <= RATE_W'(48000);
      in_count_r  <= '0;
      out_total_r <= '0;
      out_index_r <= '0;
      left_r      <= '0;
      ph_r        <= '0;
      len_ready_r <= 1'b0;
      ovf_r       <= 1'b0;
      span_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      in_count_r  <= in_count_nxt;
      out_total_r <= out_total_nxt;
      out_index_r <= out_index_nxt;
      left_r      <= left_nxt;
      ph_r        <= ph_nxt;
      len_ready_r <= len_ready_nxt;
      ovf_r       <= ovf_nxt;
      span_r      <= span_nxt;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_IN_RATE:  in_rate_r  <= cfg_wdata;
          REG_OUT_RATE: out_rate_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    whole_r <= whole_nxt;
    frac_r  <= frac_nxt;
    sl_r    <= sl_nxt;
    neg_r   <= neg_nxt;
    prod_r  <= prod_nxt;
    nneg_r  <= nneg_nxt;
    samp_r  <= samp_nxt;
    last_r  <= last_nxt;
    none_r  <= none_nxt;
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_sample      = samp_r;
  assign out_last        = last_r;
  assign out_none_left   = none_r;
  assign out_truncated   = ovf_r;
  assign out_total_count = out_total_r;

endmodule

// ===== design/lir_div.sv =====
// ----------------------------------------------------------------------------
// lir_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lir_div #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 30
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int CW = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_diff;
  logic             qbit;
  logic [DEN_W-1:0] rem_nxt;

  always_comb begin
    rem_sh   = {rem_r, quo_r[NUM_W-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    qbit     = ~rem_diff[DEN_W];
    rem_nxt  = qbit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CW'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule
